>>> hw/rtl/okl_pkg.sv
// ----------------------------------------------------------------------------
// okl_pkg
// Shared types and codes for the opposing-key last-input-priority unit.
// ----------------------------------------------------------------------------
package okl_pkg;

   localparam int CODE_W = 32;
   localparam int TIME_W = 63;

   // action codes
   localparam logic ACT_PRESS   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   typedef struct packed {
      logic              action;
      logic [CODE_W-1:0] key_code;
      logic [CODE_W-1:0] opposite_code;
      logic [TIME_W-1:0] event_time;
   } okl_req_type;

   typedef struct packed {
      logic [CODE_W-1:0] emit_code;
      logic              emit_pressed;
      logic [TIME_W-1:0] emit_time;
      logic              last_of_run;
   } okl_rsp_type;

   // one pair table entry
   typedef struct packed {
      logic [CODE_W-1:0] key;
      logic [CODE_W-1:0] opposite;
      logic              held;
      logic              active;
   } okl_entry_type;

   // pending result of the item in flight
   typedef struct packed {
      logic              vld;
      logic [CODE_W-1:0] code;
      logic              pressed;
   } okl_slot_type;

   // word handed from the sequencer to the output register
   typedef struct packed {
      logic        valid;
      okl_rsp_type word;
   } okl_emit_type;

endpackage

>>> hw/rtl/okl_table_ram.sv
// ----------------------------------------------------------------------------
// okl_table_ram
// Pair table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module okl_table_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  okl_pkg::okl_entry_type wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output okl_pkg::okl_entry_type rd_data
);

   okl_pkg::okl_entry_type mem_ff [DEPTH];
   okl_pkg::okl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/okl_ctrl.sv
// ----------------------------------------------------------------------------
// okl_ctrl
// Sequencer: scans the pair table, updates the item's own entry and its
// opposer entry by read-modify-write, and queues up to two result words.
// ----------------------------------------------------------------------------
module okl_ctrl #(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W         = 4,
   parameter int CNT_W         = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  okl_pkg::okl_req_type   req_data,
   output logic                   wr_en,
   output logic [IDX_W-1:0]       wr_addr,
   output okl_pkg::okl_entry_type wr_data,
   output logic                   rd_en,
   output logic [IDX_W-1:0]       rd_addr,
   input  okl_pkg::okl_entry_type rd_data,
   output okl_pkg::okl_emit_type  emit,
   input  logic                   emit_ready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_OPP_RD,
      ST_OPP_CHK,
      ST_SELF_ACT,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   okl_pkg::okl_req_type item_ff, item_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]     pipe_idx_ff, pipe_idx_in;
   logic                 self_fnd_ff, self_fnd_in;
   logic                 self_act_ff, self_act_in;
   logic [IDX_W-1:0]     self_idx_ff, self_idx_in;
   logic                 opp_fnd_ff, opp_fnd_in;
   logic [IDX_W-1:0]     opp_idx_ff, opp_idx_in;
   okl_pkg::okl_slot_type slot0_ff, slot0_in;
   okl_pkg::okl_slot_type slot1_ff, slot1_in;
   logic                 emit_sel_ff, emit_sel_in;

   logic is_press;
   logic tbl_full;

   assign is_press = (item_ff.action == okl_pkg::ACT_PRESS);
   assign tbl_full = (count_ff == CNT_W'(TABLE_ENTRIES));

   always_comb begin
      logic [IDX_W-1:0]      sidx;
      okl_pkg::okl_slot_type cur;

      state_in    = state_ff;
      item_in     = item_ff;
      count_in    = count_ff;
      rd_cnt_in   = rd_cnt_ff;
      pipe_vld_in = 1'b0;
      pipe_idx_in = pipe_idx_ff;
      self_fnd_in = self_fnd_ff;
      self_act_in = self_act_ff;
      self_idx_in = self_idx_ff;
      opp_fnd_in  = opp_fnd_ff;
      opp_idx_in  = opp_idx_ff;
      slot0_in    = slot0_ff;
      slot1_in    = slot1_ff;
      emit_sel_in = emit_sel_ff;

      req_ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = self_idx_ff;
      wr_data   = '{key: item_ff.key_code, opposite: item_ff.opposite_code,
                    held: 1'b1, active: 1'b1};
      rd_en     = 1'b0;
      rd_addr   = rd_cnt_ff[IDX_W-1:0];
      emit      = '0;

      sidx = self_fnd_ff ? self_idx_ff : count_ff[IDX_W-1:0];
      cur  = emit_sel_ff ? slot1_ff : slot0_ff;

      // compare the word read in the previous scan cycle; first hit wins
      if (pipe_vld_ff) begin
         if (!self_fnd_ff && rd_data.key == item_ff.key_code &&
             rd_data.opposite == item_ff.opposite_code) begin
            self_fnd_in = 1'b1;
            self_idx_in = pipe_idx_ff;
            self_act_in = rd_data.active;
         end
         if (!opp_fnd_ff && rd_data.opposite == item_ff.key_code) begin
            opp_fnd_in = 1'b1;
            opp_idx_in = pipe_idx_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in     = req_data;
               rd_cnt_in   = '0;
               self_fnd_in = 1'b0;
               self_act_in = 1'b0;
               opp_fnd_in  = 1'b0;
               slot0_in    = '0;
               slot1_in    = '0;
               emit_sel_in = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_cnt_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_addr     = rd_cnt_ff[IDX_W-1:0];
               rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
               pipe_vld_in = 1'b1;
               pipe_idx_in = rd_cnt_ff[IDX_W-1:0];
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (is_press) begin
               if (!self_fnd_ff && tbl_full) begin
                  state_in = ST_IDLE;
               end else begin
                  // mark held; active stays until the opposer is resolved
                  wr_en       = 1'b1;
                  wr_addr     = sidx;
                  wr_data     = '{key: item_ff.key_code,
                                  opposite: item_ff.opposite_code,
                                  held: 1'b1,
                                  active: self_fnd_ff & self_act_ff};
                  self_idx_in = sidx;
                  if (!self_fnd_ff) begin
                     count_in = count_ff + CNT_W'(1);
                     // freshly appended key that opposes itself
                     if (!opp_fnd_ff && item_ff.opposite_code == item_ff.key_code) begin
                        opp_fnd_in = 1'b1;
                        opp_idx_in = sidx;
                     end
                  end
                  slot1_in = '{vld: 1'b1, code: item_ff.key_code, pressed: 1'b1};
                  if (opp_fnd_ff ||
                      (!self_fnd_ff && item_ff.opposite_code == item_ff.key_code)) begin
                     state_in = ST_OPP_RD;
                  end else begin
                     state_in = ST_SELF_ACT;
                  end
               end
            end else begin
               if (!self_fnd_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = self_idx_ff;
                  wr_data  = '{key: item_ff.key_code,
                               opposite: item_ff.opposite_code,
                               held: 1'b0, active: 1'b0};
                  slot0_in = '{vld: self_act_ff, code: item_ff.key_code,
                               pressed: 1'b0};
                  state_in = opp_fnd_ff ? ST_OPP_RD : ST_EMIT;
               end
            end
         end
         ST_OPP_RD: begin
            // own entry was written last cycle, so this read sees it
            rd_en    = 1'b1;
            rd_addr  = opp_idx_ff;
            state_in = ST_OPP_CHK;
         end
         ST_OPP_CHK: begin
            wr_addr = opp_idx_ff;
            if (is_press) begin
               if (rd_data.held && rd_data.active) begin
                  wr_en    = 1'b1;
                  wr_data  = '{key: rd_data.key, opposite: rd_data.opposite,
                               held: rd_data.held, active: 1'b0};
                  slot0_in = '{vld: 1'b1, code: rd_data.key, pressed: 1'b0};
               end
               state_in = ST_SELF_ACT;
            end else begin
               if (rd_data.held && !rd_data.active) begin
                  wr_en    = 1'b1;
                  wr_data  = '{key: rd_data.key, opposite: rd_data.opposite,
                               held: rd_data.held, active: 1'b1};
                  slot1_in = '{vld: 1'b1, code: rd_data.key, pressed: 1'b1};
               end
               state_in = ST_EMIT;
            end
         end
         ST_SELF_ACT: begin
            // after the opposer write, so a self-opposed key ends active
            wr_en    = 1'b1;
            wr_addr  = self_idx_ff;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            emit.valid = cur.vld;
            emit.word  = '{emit_code: cur.code, emit_pressed: cur.pressed,
                           emit_time: item_ff.event_time,
                           last_of_run: emit_sel_ff | ~slot1_ff.vld};
            if (!cur.vld || emit_ready) begin
               if (emit_sel_ff || !slot1_ff.vld) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_sel_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         pipe_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         pipe_vld_ff <= pipe_vld_in;
      end
      item_ff     <= item_in;
      rd_cnt_ff   <= rd_cnt_in;
      pipe_idx_ff <= pipe_idx_in;
      self_fnd_ff <= self_fnd_in;
      self_act_ff <= self_act_in;
      self_idx_ff <= self_idx_in;
      opp_fnd_ff  <= opp_fnd_in;
      opp_idx_ff  <= opp_idx_in;
      slot0_ff    <= slot0_in;
      slot1_ff    <= slot1_in;
      emit_sel_ff <= emit_sel_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("pair count beyond table size");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SCAN)
      else $error("accepted word did not start a scan");

   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |-> rd_cnt_ff == count_ff && !pipe_vld_ff)
      else $error("decision taken before scan drained");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && count_ff != $past(count_ff) |->
         $past(state_ff) == ST_DECIDE && $past(is_press) && !$past(tbl_full))
      else $error("pair count changed outside an append");

endmodule

>>> hw/rtl/okl_rsp_reg.sv
// ----------------------------------------------------------------------------
// okl_rsp_reg
// Output register for result words; frees the sequencer while a word waits.
// ----------------------------------------------------------------------------
module okl_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  okl_pkg::okl_emit_type emit,
   output logic                  emit_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output okl_pkg::okl_rsp_type  rsp_data
);

   logic                 rsp_valid_ff;
   okl_pkg::okl_rsp_type rsp_data_ff;

   assign emit_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid && emit_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit.valid && emit_ready) begin
         rsp_data_ff <= emit.word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/opposing_key_last_input_priority_unit.sv
// ----------------------------------------------------------------------------
// opposing_key_last_input_priority_unit
// Last-input-priority resolver for opposing key pairs, table held in RAM.
// ----------------------------------------------------------------------------
//  channel | ports                          | word
//  --------+--------------------------------+-------------------------------
//  request | req_valid, req_ready, req_data | action, key, opposite, time
//  result  | rsp_valid, rsp_ready, rsp_data | code, pressed, time, last
//
//  One key event at a time. The table RAM's single read port sets the
//  cost: a linear scan over the stored pairs, then the update steps, then
//  the emit step, which hands out each result word in turn and is reached
//  even with no word unless the event is dropped. Reset clears the pair
//  count and the sequencer state only; entries past the count are never
//  read, so there is no clearing pass. A stalled result waits in the output
//  register; the sequencer holds in its emit step until the register frees.
// ----------------------------------------------------------------------------
module opposing_key_last_input_priority_unit #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  okl_pkg::okl_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output okl_pkg::okl_rsp_type rsp_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   okl_pkg::okl_entry_type wr_data;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   okl_pkg::okl_entry_type rd_data;
   okl_pkg::okl_emit_type  emit;
   logic                   emit_ready;

   okl_table_ram #(
      .DEPTH  (TABLE_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   okl_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W),
      .CNT_W         (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .emit       (emit),
      .emit_ready (emit_ready)
   );

   okl_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .emit_ready (emit_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> tb/okl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okl_checker
// Watches the request and result channels of the resolver. It keeps its own
// copy of the pair table, predicts the key changes that each accepted request
// word causes, and compares every accepted result word with the oldest one.
// ----------------------------------------------------------------------------
module okl_checker #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  okl_pkg::okl_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  okl_pkg::okl_rsp_type rsp_data,
   output int                   fail_count,
   output int                   pending_emits,
   output int                   emits_checked
);

   okl_pkg::okl_entry_type pair_table [TABLE_ENTRIES];
   int                     pair_count;
   okl_pkg::okl_rsp_type   expected_emits [$];

   function automatic int find_pair(logic [okl_pkg::CODE_W-1:0] k,
                                    logic [okl_pkg::CODE_W-1:0] o);
      int i;
      for (i = 0; i < pair_count; i++) begin
         if (pair_table[i].key == k && pair_table[i].opposite == o) return i;
      end
      return -1;
   endfunction

   // first entry, lowest index, that names k as its opposite
   function automatic int find_opposer(logic [okl_pkg::CODE_W-1:0] k);
      int i;
      for (i = 0; i < pair_count; i++) begin
         if (pair_table[i].opposite == k) return i;
      end
      return -1;
   endfunction

   function automatic okl_pkg::okl_rsp_type key_change(logic [okl_pkg::CODE_W-1:0] code,
                                                       logic pressed,
                                                       logic [okl_pkg::TIME_W-1:0] stamp);
      okl_pkg::okl_rsp_type r;
      r.emit_code    = code;
      r.emit_pressed = pressed;
      r.emit_time    = stamp;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   task automatic resolve_key_event(input okl_pkg::okl_req_type w);
      int                   own;
      int                   opp;
      okl_pkg::okl_rsp_type run [$];
      own = find_pair(w.key_code, w.opposite_code);
      if (w.action == okl_pkg::ACT_PRESS) begin
         if (own < 0) begin
            // table full: the word is dropped
            if (pair_count >= TABLE_ENTRIES) return;
            own = pair_count;
            pair_table[own] = '{key: w.key_code, opposite: w.opposite_code,
                                held: 1'b0, active: 1'b0};
            pair_count++;
         end
         pair_table[own].held = 1'b1;
         opp = find_opposer(w.key_code);
         if (opp >= 0 && pair_table[opp].held && pair_table[opp].active) begin
            pair_table[opp].active = 1'b0;
            run.push_back(key_change(pair_table[opp].key, 1'b0, w.event_time));
         end
         pair_table[own].active = 1'b1;
         run.push_back(key_change(w.key_code, 1'b1, w.event_time));
      end else begin
         if (own < 0) return;
         pair_table[own].held = 1'b0;
         if (pair_table[own].active) begin
            pair_table[own].active = 1'b0;
            run.push_back(key_change(w.key_code, 1'b0, w.event_time));
         end
         // opposing key still held down gets its press back
         opp = find_opposer(w.key_code);
         if (opp >= 0 && pair_table[opp].held && !pair_table[opp].active) begin
            pair_table[opp].active = 1'b1;
            run.push_back(key_change(pair_table[opp].key, 1'b1, w.event_time));
         end
      end
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i]) expected_emits.push_back(run[i]);
   endtask

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_emit(input okl_pkg::okl_rsp_type want,
                             input okl_pkg::okl_rsp_type got);
      check_field("emit_code", 64'(want.emit_code), 64'(got.emit_code));
      check_field("emit_pressed", 64'(want.emit_pressed), 64'(got.emit_pressed));
      check_field("emit_time", 64'(want.emit_time), 64'(got.emit_time));
      check_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pair_count    = 0;
         fail_count    = 0;
         emits_checked = 0;
         expected_emits.delete();
      end else begin
         if (req_valid && req_ready) resolve_key_event(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_emits.size() == 0) begin
               $error("result word with nothing expected: code %0h pressed %0b time %0h",
                      rsp_data.emit_code, rsp_data.emit_pressed, rsp_data.emit_time);
               fail_count++;
            end else begin
               check_emit(expected_emits.pop_front(), rsp_data);
            end
            emits_checked++;
         end
      end
      pending_emits = expected_emits.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives key press and release words into the resolver: a directed opening
// on a few fixed pairs, then random traffic over a pool of bound pairs with
// noise, random idling on both channels, a long result stall and a drain.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int TABLE_ENTRIES   = 16;
   localparam int EVENT_GOAL      = 1250;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam logic [okl_pkg::TIME_W-1:0] TIME_MAX = '1;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   okl_pkg::okl_req_type req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   okl_pkg::okl_rsp_type rsp_data;

   int fail_count;
   int pending_emits;
   int emits_checked;

   bit idle_on          = 1'b1;
   bit hold_off_request = 1'b0;

   logic [okl_pkg::CODE_W-1:0] code_pool [8];
   logic [okl_pkg::CODE_W-1:0] bind_key  [TABLE_ENTRIES];
   logic [okl_pkg::CODE_W-1:0] bind_opp  [TABLE_ENTRIES];
   bit                         bind_held [TABLE_ENTRIES];
   int                         bind_count     = 0;
   int                         useful_events  = 0;
   int                         ignored_events = 0;
   int                         press_count    = 0;
   int                         release_count  = 0;

   opposing_key_last_input_priority_unit #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   okl_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_emits (pending_emits),
      .emits_checked (emits_checked)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("opposing_key_last_input_priority_unit: mismatch");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(99) < 25);
         end
      end
   end

   function automatic logic [okl_pkg::TIME_W-1:0] random_time();
      logic [63:0] wide;
      int          roll;
      wide = {$urandom, $urandom};
      roll = $urandom_range(19);
      if (roll == 0) return '0;
      if (roll == 1) return TIME_MAX;
      return wide[okl_pkg::TIME_W-1:0];
   endfunction

   function automatic logic [okl_pkg::CODE_W-1:0] pool_or_random(int pool_pct);
      if ($urandom_range(99) < pool_pct) return code_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   // valid stays high into the next word unless an idle gap follows
   task automatic send_word(input okl_pkg::okl_req_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      if (idle_on && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (idle_on && $urandom_range(99) < 25);
      end
   endtask

   task automatic key_event(input logic act, input logic [okl_pkg::CODE_W-1:0] k,
                            input logic [okl_pkg::CODE_W-1:0] o,
                            input logic [okl_pkg::TIME_W-1:0] stamp);
      int                   idx;
      int                   i;
      okl_pkg::okl_req_type w;
      idx = -1;
      for (i = 0; i < bind_count; i++) begin
         if (bind_key[i] == k && bind_opp[i] == o) idx = i;
      end
      if (act == okl_pkg::ACT_PRESS && idx < 0 && bind_count < TABLE_ENTRIES) begin
         idx = bind_count;
         bind_key[idx] = k;
         bind_opp[idx] = o;
         bind_count++;
      end
      if (idx < 0) begin
         ignored_events++;
      end else begin
         useful_events++;
         bind_held[idx] = (act == okl_pkg::ACT_PRESS);
      end
      if (act == okl_pkg::ACT_PRESS) press_count++;
      else release_count++;
      w.action        = act;
      w.key_code      = k;
      w.opposite_code = o;
      w.event_time    = stamp;
      send_word(w);
   endtask

   initial begin
      int roll;
      int idx;
      int i;
      bit hold_done;
      bit pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      code_pool[0] = '0;
      code_pool[1] = '1;
      for (i = 2; i < 8; i++) code_pool[i] = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening on fixed pairs
      key_event(okl_pkg::ACT_RELEASE, code_pool[0], code_pool[1], '0);     // unknown pair
      key_event(okl_pkg::ACT_PRESS,   code_pool[0], code_pool[1], TIME_MAX);
      key_event(okl_pkg::ACT_PRESS,   code_pool[1], code_pool[0], random_time()); // takes over
      key_event(okl_pkg::ACT_RELEASE, code_pool[1], code_pool[0], random_time()); // hands back
      key_event(okl_pkg::ACT_PRESS,   code_pool[0], code_pool[1], random_time()); // repeat
      key_event(okl_pkg::ACT_RELEASE, code_pool[0], code_pool[1], random_time());
      key_event(okl_pkg::ACT_PRESS,   code_pool[2], code_pool[2], random_time()); // self opp
      key_event(okl_pkg::ACT_PRESS,   code_pool[2], code_pool[2], random_time());
      key_event(okl_pkg::ACT_RELEASE, code_pool[2], code_pool[2], random_time());
      key_event(okl_pkg::ACT_PRESS,   code_pool[3], code_pool[0], random_time()); // opposers
      key_event(okl_pkg::ACT_PRESS,   code_pool[4], code_pool[0], random_time());
      key_event(okl_pkg::ACT_PRESS,   code_pool[0], code_pool[1], random_time());
      key_event(okl_pkg::ACT_PRESS,   code_pool[1], code_pool[0], random_time());
      key_event(okl_pkg::ACT_RELEASE, code_pool[0], code_pool[1], random_time()); // no result
      key_event(okl_pkg::ACT_RELEASE, code_pool[1], code_pool[0], random_time());
      key_event(okl_pkg::ACT_RELEASE, code_pool[3], code_pool[0], random_time());
      key_event(okl_pkg::ACT_RELEASE, code_pool[4], code_pool[0], random_time());
      key_event(okl_pkg::ACT_RELEASE, code_pool[2], code_pool[2], TIME_MAX);

      while (press_count + release_count < EVENT_GOAL) begin
         idle_on = !(useful_events >= 450 && useful_events < 650);
         if (!hold_done && useful_events >= 300) begin
            hold_done = 1'b1;
            hold_off_request = 1'b1;
         end
         if (!pause_done && useful_events >= 800) begin
            pause_done = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            wait (pending_emits == 0);
         end
         roll = $urandom_range(99);
         if (bind_count == 0 || roll < 12) begin
            // press on a pool or random pair; a new one is dropped once the table is full
            key_event(okl_pkg::ACT_PRESS, pool_or_random(75), pool_or_random(80),
                      random_time());
         end else if (roll < 18) begin
            key_event(okl_pkg::ACT_RELEASE, pool_or_random(40), pool_or_random(40),
                      random_time());
         end else begin
            idx = $urandom_range(bind_count - 1);
            if ($urandom_range(99) < 80)
               key_event(bind_held[idx] ? okl_pkg::ACT_RELEASE : okl_pkg::ACT_PRESS,
                         bind_key[idx], bind_opp[idx], random_time());
            else
               key_event(logic'($urandom_range(1)), bind_key[idx], bind_opp[idx],
                         random_time());
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_emits == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d key words (%0d presses, %0d releases), %0d dropped or unknown.",
               press_count + release_count, press_count, release_count, ignored_events);
      $display("Checked %0d result words over %0d bound pairs.", emits_checked, bind_count);
      if (fail_count == 0) begin
         $display("opposing_key_last_input_priority_unit: match");
      end else begin
         $display("opposing_key_last_input_priority_unit: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/okl_pkg.sv
hw/rtl/okl_table_ram.sv
hw/rtl/okl_ctrl.sv
hw/rtl/okl_rsp_reg.sv
hw/rtl/opposing_key_last_input_priority_unit.sv
tb/okl_checker.sv
tb/tb_top.sv
